/* src/aarm_pkg.sv */
// shared constants, tables and helpers for the axis-angle rotation matrix block
`default_nettype none
package aarm_pkg;

   // cordic iteration count and arctangent table size
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_RUN   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

   // normalization pipeline: square root then three-lane division
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;
   localparam int NORM_LAT   = SQRT_STEPS + DIV_STEPS;

   // sine and cosine wait for the unit axis
   localparam int CS_DELAY = NORM_LAT - CORDIC_RUN;

   // input register, normalization, three matrix stages
   localparam int PIPE_LAT = NORM_LAT + 4;

   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032875;
   localparam logic signed [34:0] ONE_Q30  = 35'sd1073741824;
   localparam logic signed [15:0] ONE_Q14  = 16'sd16384;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic signed [33:0] atan_turn(input int i);
      logic signed [33:0] r;
      case (i)
         0:       r = 34'sh020000000;
         1:       r = 34'sh012E4051E;
         2:       r = 34'sh009FB385B;
         3:       r = 34'sh0051111D4;
         4:       r = 34'sh0028B0D43;
         5:       r = 34'sh00145D7E1;
         6:       r = 34'sh000A2F61E;
         7:       r = 34'sh000517C55;
         8:       r = 34'sh00028BE53;
         9:       r = 34'sh000145F2F;
         10:      r = 34'sh0000A2F98;
         11:      r = 34'sh0000517CC;
         12:      r = 34'sh000028BE6;
         13:      r = 34'sh0000145F3;
         14:      r = 34'sh00000A2FA;
         15:      r = 34'sh00000517D;
         16:      r = 34'sh0000028BE;
         17:      r = 34'sh00000145F;
         18:      r = 34'sh000000A30;
         19:      r = 34'sh000000518;
         20:      r = 34'sh00000028C;
         21:      r = 34'sh000000146;
         22:      r = 34'sh0000000A3;
         23:      r = 34'sh000000051;
         default: r = 34'sh000000000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/aarm_if.sv */
// request and response channel interfaces
`default_nettype none
interface aarm_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] angle;
   logic signed [15:0] axis_x;
   logic signed [15:0] axis_y;
   logic signed [15:0] axis_z;

   modport source (output valid, angle, axis_x, axis_y, axis_z, input ready);
   modport sink   (input valid, angle, axis_x, axis_y, axis_z, output ready);
endinterface

interface aarm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] r00;
   logic signed [15:0] r01;
   logic signed [15:0] r02;
   logic signed [15:0] r10;
   logic signed [15:0] r11;
   logic signed [15:0] r12;
   logic signed [15:0] r20;
   logic signed [15:0] r21;
   logic signed [15:0] r22;
   logic               axis_invalid;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, axis_invalid,
                   input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, axis_invalid,
                   output ready);
endinterface
`default_nettype wire

/* src/axis_angle_rotation_matrix.sv */
// top level: axis-angle to rotation matrix pipeline
//
// Request words carry a binary angle (65536 per turn) and a 16-bit axis at
// any scale; each response word carries the nine Q2.14 entries of the
// rotation matrix and a flag that marks a zero axis (identity is returned).
// Both channels are valid/ready; a word moves when both are high.
// Unless stalled, one request word enters per cycle, giving exactly one response.
// The pipe has 67 register stages between the edge that takes the request
// and the response word. The depth is set by the axis
// normalization: one square-root digit per stage (32 stages), then one
// quotient bit per stage for the three components (31 stages), behind one
// input register. The sine/cosine cordic runs alongside, one iteration per
// stage, and waits in a delay line. Three stages of multiplies and rounding
// follow.
// The whole pipeline advances together whenever the output register is
// empty or being taken; while the receiver stalls, every stage holds and
// req ready is low, so nothing is lost or repeated.
// Synchronous reset clears all valid bits; the data path is not reset.
`default_nettype none
module axis_angle_rotation_matrix (
   input wire logic   clock,
   input wire logic   reset,
   aarm_req_if.sink   req_if,
   aarm_rsp_if.source rsp_if
);

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               flip;
   } cor_type;

   typedef struct packed {
      logic signed [33:0] c;
      logic signed [33:0] s;
   } cs_type;

   // one cordic rotation
   function automatic cor_type cordic_step(input cor_type p, input int i);
      cor_type            r;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      dx = p.y >>> i;
      dy = p.x >>> i;
      r  = p;
      if (!p.z[33]) begin
         r.x = p.x - dx;
         r.y = p.y + dy;
         r.z = p.z - aarm_pkg::atan_turn(i);
      end else begin
         r.x = p.x + dx;
         r.y = p.y - dy;
         r.z = p.z + aarm_pkg::atan_turn(i);
      end
      return r;
   endfunction

   logic en;
   logic vld_ff [0:aarm_pkg::PIPE_LAT-1];

   // whole pipe advances unless the output word is stalled
   assign en           = !vld_ff[aarm_pkg::PIPE_LAT-1] || rsp_if.ready;
   assign req_if.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < aarm_pkg::PIPE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_if.valid;
         for (int i = 1; i < aarm_pkg::PIPE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // input stage: squared norm, magnitudes, folded angle
   logic               flip;
   logic signed [15:0] a_fold;
   logic signed [31:0] sq_x, sq_y, sq_z;
   logic [31:0]        n2_in;
   logic [2:0][15:0]   mag_in;
   logic [2:0]         sgn_in;
   cor_type            cor0_in;

   assign flip   = req_if.angle[15] ^ req_if.angle[14];
   assign a_fold = flip ? {~req_if.angle[15], req_if.angle[14:0]} : req_if.angle;
   assign sq_x   = req_if.axis_x * req_if.axis_x;
   assign sq_y   = req_if.axis_y * req_if.axis_y;
   assign sq_z   = req_if.axis_z * req_if.axis_z;
   assign n2_in  = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
   assign sgn_in = {req_if.axis_z[15], req_if.axis_y[15], req_if.axis_x[15]};
   assign mag_in[0] = req_if.axis_x[15] ? 16'(-req_if.axis_x) : req_if.axis_x;
   assign mag_in[1] = req_if.axis_y[15] ? 16'(-req_if.axis_y) : req_if.axis_y;
   assign mag_in[2] = req_if.axis_z[15] ? 16'(-req_if.axis_z) : req_if.axis_z;

   always_comb begin
      cor0_in.x    = aarm_pkg::GAIN_Q30;
      cor0_in.y    = '0;
      cor0_in.z    = {{2{a_fold[15]}}, a_fold, 16'b0};
      cor0_in.flip = flip;
   end

   logic [31:0]      n2_ff;
   logic [2:0][15:0] mag_ff;
   logic [2:0]       sgn_ff;
   logic             inv_ff [0:aarm_pkg::NORM_LAT];
   cor_type          cor_ff [0:aarm_pkg::CORDIC_RUN];

   always_ff @(posedge clock) begin
      if (en) begin
         n2_ff     <= n2_in;
         mag_ff    <= mag_in;
         sgn_ff    <= sgn_in;
         cor_ff[0] <= cor0_in;
         inv_ff[0] <= (req_if.axis_x == 16'sd0) && (req_if.axis_y == 16'sd0)
                      && (req_if.axis_z == 16'sd0);
         for (int i = 1; i <= aarm_pkg::NORM_LAT; i++) begin
            inv_ff[i] <= inv_ff[i-1];
         end
      end
   end

   // cordic stages, one iteration each
   for (genvar i = 1; i <= aarm_pkg::CORDIC_RUN; i++) begin : g_cor
      cor_type cor_in;
      assign cor_in = cordic_step(cor_ff[i-1], i - 1);
      always_ff @(posedge clock) begin
         if (en) begin
            cor_ff[i] <= cor_in;
         end
      end
   end

   // unfold the angle and hold sine and cosine until the axis is ready
   cs_type cs_in;
   cs_type cs_ff [0:aarm_pkg::CS_DELAY-1];

   always_comb begin
      cs_in.c = cor_ff[aarm_pkg::CORDIC_RUN].flip ? -cor_ff[aarm_pkg::CORDIC_RUN].x
                                                 :  cor_ff[aarm_pkg::CORDIC_RUN].x;
      cs_in.s = cor_ff[aarm_pkg::CORDIC_RUN].flip ? -cor_ff[aarm_pkg::CORDIC_RUN].y
                                                 :  cor_ff[aarm_pkg::CORDIC_RUN].y;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cs_ff[0] <= cs_in;
         for (int i = 1; i < aarm_pkg::CS_DELAY; i++) begin
            cs_ff[i] <= cs_ff[i-1];
         end
      end
   end

   // unit axis
   logic signed [2:0][31:0] unit;

   aarm_norm u_norm (
      .clock (clock),
      .en    (en),
      .n2    (n2_ff),
      .mag   (mag_ff),
      .sgn   (sgn_ff),
      .unit  (unit)
   );

   // matrix entries
   logic signed [15:0] ent [0:8];
   logic               inv_out;

   aarm_mat u_mat (
      .clock       (clock),
      .en          (en),
      .c           (cs_ff[aarm_pkg::CS_DELAY-1].c),
      .s           (cs_ff[aarm_pkg::CS_DELAY-1].s),
      .unit        (unit),
      .invalid     (inv_ff[aarm_pkg::NORM_LAT]),
      .ent         (ent),
      .invalid_out (inv_out)
   );

   // response word
   assign rsp_if.valid        = vld_ff[aarm_pkg::PIPE_LAT-1];
   assign rsp_if.r00          = ent[0];
   assign rsp_if.r01          = ent[1];
   assign rsp_if.r02          = ent[2];
   assign rsp_if.r10          = ent[3];
   assign rsp_if.r11          = ent[4];
   assign rsp_if.r12          = ent[5];
   assign rsp_if.r20          = ent[6];
   assign rsp_if.r21          = ent[7];
   assign rsp_if.r22          = ent[8];
   assign rsp_if.axis_invalid = inv_out;

endmodule
`default_nettype wire

/* src/aarm_norm.sv */
// axis normalization: pipelined integer square root and three-lane restoring division
`default_nettype none
module aarm_norm (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic [31:0]         n2,
   input  wire logic [2:0][15:0]    mag,
   input  wire logic [2:0]          sgn,
   output logic signed [2:0][31:0]  unit
);

   typedef struct packed {
      logic [62:0]      n;
      logic [62:0]      root;
      logic [2:0][15:0] mag;
      logic [2:0]       sgn;
   } sq_type;

   typedef struct packed {
      logic [2:0][60:0] rem;
      logic [2:0][30:0] q;
      logic [31:0]      root;
      logic [2:0]       sgn;
   } div_type;

   // one root digit per stage
   function automatic sq_type sq_step(input sq_type p, input int i);
      sq_type      r;
      logic [62:0] bitv;
      logic [62:0] trial;
      bitv  = 63'(1) << (62 - 2 * i);
      trial = p.root + bitv;
      r     = p;
      if (p.n >= trial) begin
         r.n    = p.n - trial;
         r.root = (p.root >> 1) + bitv;
      end else begin
         r.root = p.root >> 1;
      end
      return r;
   endfunction

   // one quotient bit per stage in each lane
   function automatic div_type div_step(input div_type p, input int k);
      div_type     r;
      logic [62:0] d;
      d = 63'(p.root) << k;
      r = p;
      for (int l = 0; l < 3; l++) begin
         if ({2'b00, p.rem[l]} >= d) begin
            r.rem[l] = p.rem[l] - d[60:0];
            r.q[l]   = p.q[l] | (31'(1) << k);
         end
      end
      return r;
   endfunction

   sq_type  sq_ff   [0:aarm_pkg::SQRT_STEPS-1];
   sq_type  sq_prev [0:aarm_pkg::SQRT_STEPS-1];
   div_type dv_ff   [0:aarm_pkg::DIV_STEPS-1];
   div_type dv_prev [0:aarm_pkg::DIV_STEPS-1];

   // root of n2 scaled by 2^30
   always_comb begin
      sq_prev[0].n    = {1'b0, n2, 30'b0};
      sq_prev[0].root = '0;
      sq_prev[0].mag  = mag;
      sq_prev[0].sgn  = sgn;
   end

   // dividend is the axis magnitude scaled by 2^45
   always_comb begin
      dv_prev[0].root = sq_ff[aarm_pkg::SQRT_STEPS-1].root[31:0];
      dv_prev[0].sgn  = sq_ff[aarm_pkg::SQRT_STEPS-1].sgn;
      dv_prev[0].q    = '0;
      for (int l = 0; l < 3; l++) begin
         dv_prev[0].rem[l] = {sq_ff[aarm_pkg::SQRT_STEPS-1].mag[l], 45'b0};
      end
   end

   for (genvar i = 0; i < aarm_pkg::SQRT_STEPS; i++) begin : g_sq
      sq_type sq_in;
      if (i > 0) begin : g_link
         assign sq_prev[i] = sq_ff[i-1];
      end
      assign sq_in = sq_step(sq_prev[i], i);
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[i] <= sq_in;
         end
      end
   end

   for (genvar j = 0; j < aarm_pkg::DIV_STEPS; j++) begin : g_dv
      div_type dv_in;
      if (j > 0) begin : g_link
         assign dv_prev[j] = dv_ff[j-1];
      end
      assign dv_in = div_step(dv_prev[j], aarm_pkg::DIV_STEPS - 1 - j);
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[j] <= dv_in;
         end
      end
   end

   // restore the component signs
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         unit[l] = dv_ff[aarm_pkg::DIV_STEPS-1].sgn[l]
                   ? -$signed({1'b0, dv_ff[aarm_pkg::DIV_STEPS-1].q[l]})
                   :  $signed({1'b0, dv_ff[aarm_pkg::DIV_STEPS-1].q[l]});
      end
   end

endmodule
`default_nettype wire

/* src/aarm_mat.sv */
// rodrigues matrix assembly: two multiply stages and a rounding stage
`default_nettype none
module aarm_mat (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic signed [33:0]  c,
   input  wire logic signed [33:0]  s,
   input  wire logic signed [2:0][31:0] unit,
   input  wire logic                invalid,
   output logic signed [15:0]       ent [0:8],
   output logic                     invalid_out
);

   // round half up from q60 to q30
   function automatic logic signed [33:0] rnd30(input logic signed [71:0] p);
      logic signed [71:0] t;
      t = (p + 72'sd536870912) >>> 30;
      return t[33:0];
   endfunction

   // round to q14 and hold to plus or minus one
   function automatic logic signed [15:0] to_q14(input logic signed [35:0] e);
      logic signed [35:0] t;
      t = (e + 36'sd32768) >>> 16;
      if (t > 36'sd16384) begin
         t = 36'sd16384;
      end else if (t < -36'sd16384) begin
         t = -36'sd16384;
      end
      return t[15:0];
   endfunction

   logic signed [31:0] ux, uy, uz;
   assign ux = unit[0];
   assign uy = unit[1];
   assign uz = unit[2];

   // stage one: axis outer products, axis times sine
   logic signed [63:0] m_xx, m_yy, m_zz, m_xy, m_yz, m_zx;
   logic signed [65:0] m_xs, m_ys, m_zs;
   logic signed [33:0] pxx_ff, pyy_ff, pzz_ff, pxy_ff, pyz_ff, pzx_ff;
   logic signed [33:0] xs_ff, ys_ff, zs_ff, c1_ff;
   logic signed [34:0] omc_ff;
   logic               inv1_ff;

   assign m_xx = ux * ux;
   assign m_yy = uy * uy;
   assign m_zz = uz * uz;
   assign m_xy = ux * uy;
   assign m_yz = uy * uz;
   assign m_zx = uz * ux;
   assign m_xs = ux * s;
   assign m_ys = uy * s;
   assign m_zs = uz * s;

   always_ff @(posedge clock) begin
      if (en) begin
         pxx_ff  <= rnd30(72'(m_xx));
         pyy_ff  <= rnd30(72'(m_yy));
         pzz_ff  <= rnd30(72'(m_zz));
         pxy_ff  <= rnd30(72'(m_xy));
         pyz_ff  <= rnd30(72'(m_yz));
         pzx_ff  <= rnd30(72'(m_zx));
         xs_ff   <= rnd30(72'(m_xs));
         ys_ff   <= rnd30(72'(m_ys));
         zs_ff   <= rnd30(72'(m_zs));
         omc_ff  <= aarm_pkg::ONE_Q30 - 35'(c);
         c1_ff   <= c;
         inv1_ff <= invalid;
      end
   end

   // stage two: scale by one minus cosine
   logic signed [68:0] n_xx, n_yy, n_zz, n_xy, n_yz, n_zx;
   logic signed [33:0] xx_ff, yy_ff, zz_ff, xy_ff, yz_ff, zx_ff;
   logic signed [33:0] xs2_ff, ys2_ff, zs2_ff, c2_ff;
   logic               inv2_ff;

   assign n_xx = pxx_ff * omc_ff;
   assign n_yy = pyy_ff * omc_ff;
   assign n_zz = pzz_ff * omc_ff;
   assign n_xy = pxy_ff * omc_ff;
   assign n_yz = pyz_ff * omc_ff;
   assign n_zx = pzx_ff * omc_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff   <= rnd30(72'(n_xx));
         yy_ff   <= rnd30(72'(n_yy));
         zz_ff   <= rnd30(72'(n_zz));
         xy_ff   <= rnd30(72'(n_xy));
         yz_ff   <= rnd30(72'(n_yz));
         zx_ff   <= rnd30(72'(n_zx));
         xs2_ff  <= xs_ff;
         ys2_ff  <= ys_ff;
         zs2_ff  <= zs_ff;
         c2_ff   <= c1_ff;
         inv2_ff <= inv1_ff;
      end
   end

   // stage three: sums, rounding, identity for a zero axis
   logic signed [15:0] ent_in [0:8];
   logic signed [15:0] ent_ff [0:8];
   logic               inv3_ff;

   always_comb begin
      if (inv2_ff) begin
         for (int e = 0; e < 9; e++) begin
            ent_in[e] = (e % 4 == 0) ? aarm_pkg::ONE_Q14 : 16'sd0;
         end
      end else begin
         ent_in[0] = to_q14(36'(xx_ff) + 36'(c2_ff));
         ent_in[1] = to_q14(36'(xy_ff) - 36'(zs2_ff));
         ent_in[2] = to_q14(36'(zx_ff) + 36'(ys2_ff));
         ent_in[3] = to_q14(36'(xy_ff) + 36'(zs2_ff));
         ent_in[4] = to_q14(36'(yy_ff) + 36'(c2_ff));
         ent_in[5] = to_q14(36'(yz_ff) - 36'(xs2_ff));
         ent_in[6] = to_q14(36'(zx_ff) - 36'(ys2_ff));
         ent_in[7] = to_q14(36'(yz_ff) + 36'(xs2_ff));
         ent_in[8] = to_q14(36'(zz_ff) + 36'(c2_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ent_ff  <= ent_in;
         inv3_ff <= inv2_ff;
      end
   end

   assign ent         = ent_ff;
   assign invalid_out = inv3_ff;

endmodule
`default_nettype wire

/* src/aarm_checker.sv */
// port-level checks for the rotation matrix block, bound to the top level
`default_nettype none
module aarm_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [15:0] r00,
   input wire logic signed [15:0] r01,
   input wire logic signed [15:0] r02,
   input wire logic signed [15:0] r10,
   input wire logic signed [15:0] r11,
   input wire logic signed [15:0] r12,
   input wire logic signed [15:0] r20,
   input wire logic signed [15:0] r21,
   input wire logic signed [15:0] r22,
   input wire logic               axis_invalid
);

   // a stalled word stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // a stalled word keeps its diagonal entries and its invalid flag
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(r00) && $stable(r11) && $stable(r22)
                                  && $stable(axis_invalid))
      else $error("response word changed while stalled");

   // an empty output stage never blocks the request side
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

   // a zero axis gives the identity
   a_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && axis_invalid |-> r00 == 16'sd16384 && r11 == 16'sd16384
         && r22 == 16'sd16384 && r01 == 16'sd0 && r02 == 16'sd0 && r10 == 16'sd0
         && r12 == 16'sd0 && r20 == 16'sd0 && r21 == 16'sd0)
      else $error("zero axis without identity matrix");

   // diagonal entries held to plus or minus one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> r00 <= 16'sd16384 && r00 >= -16'sd16384
         && r11 <= 16'sd16384 && r11 >= -16'sd16384
         && r22 <= 16'sd16384 && r22 >= -16'sd16384)
      else $error("diagonal entry out of range");

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .r00          (rsp_if.r00),
   .r01          (rsp_if.r01),
   .r02          (rsp_if.r02),
   .r10          (rsp_if.r10),
   .r11          (rsp_if.r11),
   .r12          (rsp_if.r12),
   .r20          (rsp_if.r20),
   .r21          (rsp_if.r21),
   .r22          (rsp_if.r22),
   .axis_invalid (rsp_if.axis_invalid)
);
`default_nettype wire

/* tb/sv/tb.sv */
// self-checking testbench for the axis-angle rotation matrix pipeline
`timescale 1ns / 100ps
`default_nettype none
module tb;

   typedef struct packed {
      logic signed [15:0] angle;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
   } rot_req_type;

   typedef struct packed {
      logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
      logic               invalid;
   } rot_mat_type;

   // directed row: request, expected matrix, and whether that matrix is typed in
   typedef struct {
      rot_req_type req;
      bit          typed;
      rot_mat_type mat;
   } dir_row_type;

   localparam int N_RANDOM  = 830;
   localparam int CYC_LIMIT = 400000;
   localparam int N_STEPS   = (aarm_pkg::CORDIC_STEPS < 24) ? aarm_pkg::CORDIC_STEPS : 24;

   logic clock;
   logic reset;
   aarm_req_if req_if ();
   aarm_rsp_if rsp_if ();

   axis_angle_rotation_matrix dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   rot_mat_type matrix_q[$];
   int          n_errors;
   int          n_cycles;
   int          stall_mode;
   longint      atan_tbl[24];

   localparam rot_mat_type IDENTITY = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
                                        16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b1};

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor division by a power of two
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint q30_mul(longint a, longint b);
      return floor_shift(a * b + (64'sd1 <<< 29), 30);
   endfunction

   function automatic logic signed [15:0] entry_q14(longint e);
      longint r;
      r = floor_shift(e + (64'sd1 <<< 15), 16);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint unit_comp(longint v, longint unsigned root);
      longint unsigned mag;
      longint q;
      mag = longint'(v < 0 ? -v : v) << 45;
      q = longint'(mag / root);
      return v < 0 ? -q : q;
   endfunction

   // rodrigues matrix from angle and axis
   function automatic rot_mat_type rotation_of(rot_req_type r);
      rot_mat_type m;
      longint a, vx, vy, vz, x, y, z, dx, dy, c, s, omc, ux, uy, uz;
      longint xx, yy, zz, xy, yz, zx, xs, ys, zs;
      longint unsigned n2, root;
      bit flip;
      a = r.angle; vx = r.ax; vy = r.ay; vz = r.az;
      n2 = vx * vx + vy * vy + vz * vz;
      if (n2 == 0) return IDENTITY;
      flip = 0;
      if (a >= 16384) begin
         a = a - 32768; flip = 1;
      end else if (a < -16384) begin
         a = a + 32768; flip = 1;
      end
      z = a * 65536;
      x = 652032875;
      y = 0;
      for (int i = 0; i < N_STEPS; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - atan_tbl[i];
         end else begin
            x = x + dx; y = y - dy; z = z + atan_tbl[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
      omc = 64'sd1073741824 - c;
      root = int_sqrt(n2 << 30);
      ux = unit_comp(vx, root);
      uy = unit_comp(vy, root);
      uz = unit_comp(vz, root);
      xx = q30_mul(q30_mul(ux, ux), omc);
      yy = q30_mul(q30_mul(uy, uy), omc);
      zz = q30_mul(q30_mul(uz, uz), omc);
      xy = q30_mul(q30_mul(ux, uy), omc);
      yz = q30_mul(q30_mul(uy, uz), omc);
      zx = q30_mul(q30_mul(uz, ux), omc);
      xs = q30_mul(ux, s);
      ys = q30_mul(uy, s);
      zs = q30_mul(uz, s);
      m.m00 = entry_q14(xx + c);
      m.m01 = entry_q14(xy - zs);
      m.m02 = entry_q14(zx + ys);
      m.m10 = entry_q14(xy + zs);
      m.m11 = entry_q14(yy + c);
      m.m12 = entry_q14(yz - xs);
      m.m20 = entry_q14(zx - ys);
      m.m21 = entry_q14(yz + xs);
      m.m22 = entry_q14(zz + c);
      m.invalid = 1'b0;
      return m;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, n_cycles);
      n_errors++;
   endtask

   // response checking against the oldest expected matrix
   always @(posedge clock) begin
      rot_mat_type w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (matrix_q.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            w = matrix_q.pop_front();
            if (rsp_if.r00 !== w.m00) report_mismatch("r00", rsp_if.r00, w.m00);
            if (rsp_if.r01 !== w.m01) report_mismatch("r01", rsp_if.r01, w.m01);
            if (rsp_if.r02 !== w.m02) report_mismatch("r02", rsp_if.r02, w.m02);
            if (rsp_if.r10 !== w.m10) report_mismatch("r10", rsp_if.r10, w.m10);
            if (rsp_if.r11 !== w.m11) report_mismatch("r11", rsp_if.r11, w.m11);
            if (rsp_if.r12 !== w.m12) report_mismatch("r12", rsp_if.r12, w.m12);
            if (rsp_if.r20 !== w.m20) report_mismatch("r20", rsp_if.r20, w.m20);
            if (rsp_if.r21 !== w.m21) report_mismatch("r21", rsp_if.r21, w.m21);
            if (rsp_if.r22 !== w.m22) report_mismatch("r22", rsp_if.r22, w.m22);
            if (rsp_if.axis_invalid !== w.invalid)
               report_mismatch("axis_invalid", rsp_if.axis_invalid, w.invalid);
         end
      end
   end

   // receiver stall pattern, mode changes over the run
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(3) != 0);
            2: rsp_if.ready <= (n_cycles % 7) < 3;
            default: rsp_if.ready <= ($urandom_range(1) == 0);
         endcase
      end
   end

   // cycle counter and timeout
   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles > CYC_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // one word: drive, hold until taken, queue the prediction
   task automatic send_word(rot_req_type r, rot_mat_type want);
      req_if.valid  <= 1'b1;
      req_if.angle  <= r.angle;
      req_if.axis_x <= r.ax;
      req_if.axis_y <= r.ay;
      req_if.axis_z <= r.az;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      matrix_q.push_back(want);
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return $signed(16'($urandom_range(7))) - 16'sd3;
         default: return 16'($urandom);
      endcase
   endfunction

   dir_row_type dir_tbl[$];

   task automatic add_row(int an, int x, int y, int z, bit typed, rot_mat_type m);
      dir_row_type d;
      d.req = '{16'(an), 16'(x), 16'(y), 16'(z)};
      d.typed = typed;
      d.mat = m;
      dir_tbl.push_back(d);
   endtask

   initial begin
      rot_req_type r;
      rot_mat_type none;
      int burst;
      none = '0;
      atan_tbl = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                   64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                   64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                   64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
                   64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                   64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
      stall_mode = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.angle = '0;
      req_if.axis_x = '0;
      req_if.axis_y = '0;
      req_if.axis_z = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: zero axis cases, extremes, quarter-turn folding boundaries
      add_row(0, 0, 0, 0, 1, IDENTITY);
      add_row(32767, 0, 0, 0, 1, IDENTITY);
      add_row(-32768, 0, 0, 0, 1, IDENTITY);
      add_row(0, 1, 0, 0, 0, none);
      add_row(0, 0, 32767, 0, 0, none);
      add_row(16383, 0, 0, 1, 0, none);
      add_row(16384, 0, 0, 1, 0, none);
      add_row(-16384, 1, 0, 0, 0, none);
      add_row(-16385, 1, 0, 0, 0, none);
      add_row(-32768, 0, 1, 0, 0, none);
      add_row(32767, -32768, 0, 0, 0, none);
      add_row(8192, 32767, 32767, 32767, 0, none);
      add_row(-8192, -32768, -32768, -32768, 0, none);
      add_row(21845, 1, 1, 1, 0, none);
      add_row(-1, -1, 2, -3, 0, none);
      add_row(1, 32767, -32768, 1, 0, none);
      add_row(12345, 0, -32768, 32767, 0, none);
      add_row(-21000, 3, 0, -4, 0, none);
      foreach (dir_tbl[i])
         send_word(dir_tbl[i].req, dir_tbl[i].typed ? dir_tbl[i].mat :
                   rotation_of(dir_tbl[i].req));

      // hold off until the pipe has drained
      req_if.valid <= 1'b0;
      while (matrix_q.size() != 0) @(posedge clock);

      // random bursts with gaps, receiver mode changing per quarter
      for (int k = 0; k < N_RANDOM; k += burst) begin
         stall_mode = (k * 4) / N_RANDOM;
         burst = $urandom_range(40, 1);
         for (int j = 0; j < burst; j++) begin
            r.angle = ($urandom_range(5) == 0) ? rand_comp() : 16'($urandom);
            r.ax = rand_comp();
            r.ay = rand_comp();
            r.az = rand_comp();
            send_word(r, rotation_of(r));
         end
         if ($urandom_range(2) != 0) idle_gap($urandom_range(12));
      end
      req_if.valid <= 1'b0;
      stall_mode = 1;

      while (matrix_q.size() != 0) @(posedge clock);
      repeat (aarm_pkg::PIPE_LAT + 10) @(posedge clock);
      if (n_errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
